>>> src/vna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_pkg
// Shared constants, codes and controller/datapath interface types for the
// vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);

  localparam int SLOT_W = 10;
  localparam int POS_W  = 24;
  localparam int NORM_W = 16;
  localparam int SUM_W  = 24;
  localparam int EDGE_W = POS_W + 1;
  localparam int CR_W   = 52;
  localparam int MAG_W  = CR_W;
  localparam int L2_W   = 62;
  localparam int SQ_W   = 64;
  localparam int LEN_W  = 31;
  localparam int REM_W  = 47;
  localparam int Q_W    = 16;
  localparam int FRAC_W = 14;

  localparam int CROSS_STEPS = 6;
  localparam int SQ_STEPS    = 3;
  localparam int ROOT_STEPS  = L2_W / 2 + 1;
  localparam int DIV_STEPS   = Q_W;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TRI  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD,
    ST_TRI_RA, ST_TRI_RB, ST_TRI_RC, ST_TRI_E2, ST_CROSS, ST_CROSS_LD,
    ST_Q_RD, ST_Q_LD, ST_NORM, ST_SQ, ST_ROOT_INIT, ST_ROOT,
    ST_DIV_INIT, ST_DIV, ST_ACC_RD, ST_ACC_WR, ST_OUT
  } state_t;

  typedef enum logic [1:0] {SEL_A, SEL_B, SEL_C, SEL_SLOT} addr_sel_t;
  typedef enum logic [1:0] {SW_NONE, SW_CLEAR, SW_ZERO, SW_ACC} sum_wr_t;
  typedef enum logic [1:0] {NS_CROSS, NS_SUM, NS_ZERO} norm_src_t;
  typedef enum logic {MK_CROSS, MK_SQUARE} mul_kind_t;

  typedef struct packed {
    logic              capture;
    logic              pos_we;
    logic              pos_re;
    logic              sum_re;
    sum_wr_t           sum_wr;
    addr_sel_t         sel;
    logic [ADDR_W-1:0] clr_addr;
    logic              lat_a;
    logic              lat_e1;
    logic              lat_e2;
    mul_kind_t         mul_kind;
    logic              mul_en;
    logic              acc_en;
    logic [2:0]        mul_idx;
    logic [2:0]        acc_idx;
    logic              norm_load;
    norm_src_t         norm_src;
    logic              norm_shr;
    logic              norm_shl;
    logic              root_init;
    logic              root_step;
    logic              div_init;
    logic              div_step;
    logic              div_store;
    logic [1:0]        comp;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic       mag_zero;
    logic       mag_hi;
    logic       mag_lo;
    logic       out_free;
    logic       slot_ok;
    logic       tri_ok;
    logic [1:0] func;
  } sts_t;

endpackage

>>> src/vna_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_ctrl
// Sequencer: reset clearing sweep, load, triangle and read flows, shared
// normalize / square root / divide steps.
// ----------------------------------------------------------------------------
module vna_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  input  vna_pkg::sts_t sts,
  output vna_pkg::cmd_t cmd,
  output logic          in_stall
);
  import vna_pkg::*;

  state_t            state_r, state_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  function automatic addr_sel_t corner_sel(input logic [1:0] k);
    addr_sel_t s;
    unique case (k)
      2'd0:    s = SEL_A;
      2'd1:    s = SEL_B;
      default: s = SEL_C;
    endcase
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      comp_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(VERTEX_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_LOAD: state_nxt = ST_LOAD;
            FUNC_TRI:  state_nxt = ST_TRI_RA;
            FUNC_READ: state_nxt = ST_Q_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:   state_nxt = ST_IDLE;
      ST_TRI_RA: state_nxt = sts.tri_ok ? ST_TRI_RB : ST_IDLE;
      ST_TRI_RB: state_nxt = ST_TRI_RC;
      ST_TRI_RC: state_nxt = ST_TRI_E2;
      ST_TRI_E2: begin
        state_nxt = ST_CROSS;
        cnt_nxt   = '0;
      end
      ST_CROSS: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'(CROSS_STEPS)) state_nxt = ST_CROSS_LD;
      end
      ST_CROSS_LD: state_nxt = ST_NORM;
      ST_Q_RD:     state_nxt = ST_Q_LD;
      ST_Q_LD:     state_nxt = ST_NORM;
      ST_NORM: begin
        priority if (sts.mag_zero) begin
          state_nxt = (sts.func == FUNC_TRI) ? ST_IDLE : ST_OUT;
        end else if (sts.mag_hi || sts.mag_lo) begin
          state_nxt = ST_NORM;
        end else begin
          state_nxt = ST_SQ;
          cnt_nxt   = '0;
        end
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'(SQ_STEPS)) state_nxt = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: begin
        state_nxt = ST_ROOT;
        cnt_nxt   = '0;
      end
      ST_ROOT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'(ROOT_STEPS - 1)) begin
          state_nxt = ST_DIV_INIT;
          comp_nxt  = '0;
        end
      end
      ST_DIV_INIT: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          if (comp_r == 2'd2) begin
            state_nxt = (sts.func == FUNC_TRI) ? ST_ACC_RD : ST_OUT;
            comp_nxt  = '0;
          end else begin
            state_nxt = ST_DIV_INIT;
            comp_nxt  = comp_r + 1'b1;
          end
        end
      end
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: begin
        if (comp_r == 2'd2) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ACC_RD;
          comp_nxt  = comp_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sum_wr   = SW_CLEAR;
        cmd.clr_addr = clr_r;
      end
      ST_IDLE: cmd.capture = in_valid;
      ST_LOAD: begin
        cmd.sel    = SEL_SLOT;
        cmd.pos_we = sts.slot_ok;
        cmd.sum_wr = sts.slot_ok ? SW_ZERO : SW_NONE;
      end
      ST_TRI_RA: begin
        cmd.pos_re = 1'b1;
        cmd.sel    = SEL_A;
      end
      ST_TRI_RB: begin
        cmd.pos_re = 1'b1;
        cmd.sel    = SEL_B;
        cmd.lat_a  = 1'b1;
      end
      ST_TRI_RC: begin
        cmd.pos_re = 1'b1;
        cmd.sel    = SEL_C;
        cmd.lat_e1 = 1'b1;
      end
      ST_TRI_E2: cmd.lat_e2 = 1'b1;
      ST_CROSS: begin
        cmd.mul_kind = MK_CROSS;
        cmd.mul_en   = (cnt_r < 5'(CROSS_STEPS));
        cmd.acc_en   = (cnt_r != '0);
        cmd.mul_idx  = cnt_r[2:0];
        cmd.acc_idx  = cnt_r[2:0] - 3'd1;
      end
      ST_CROSS_LD: begin
        cmd.norm_load = 1'b1;
        cmd.norm_src  = NS_CROSS;
      end
      ST_Q_RD: begin
        cmd.sum_re = sts.slot_ok;
        cmd.sel    = SEL_SLOT;
      end
      ST_Q_LD: begin
        cmd.norm_load = 1'b1;
        cmd.norm_src  = sts.slot_ok ? NS_SUM : NS_ZERO;
      end
      ST_NORM: begin
        cmd.norm_shr = !sts.mag_zero && sts.mag_hi;
        cmd.norm_shl = !sts.mag_zero && !sts.mag_hi && sts.mag_lo;
      end
      ST_SQ: begin
        cmd.mul_kind = MK_SQUARE;
        cmd.mul_en   = (cnt_r < 5'(SQ_STEPS));
        cmd.acc_en   = (cnt_r != '0);
        cmd.mul_idx  = cnt_r[2:0];
        cmd.acc_idx  = cnt_r[2:0] - 3'd1;
      end
      ST_ROOT_INIT: cmd.root_init = 1'b1;
      ST_ROOT:      cmd.root_step = 1'b1;
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cmd.comp     = comp_r;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_store = (cnt_r == 5'(DIV_STEPS - 1));
        cmd.comp      = comp_r;
      end
      ST_ACC_RD: begin
        cmd.sum_re = 1'b1;
        cmd.sel    = corner_sel(comp_r);
      end
      ST_ACC_WR: begin
        cmd.sum_wr = SW_ACC;
        cmd.sel    = corner_sel(comp_r);
        cmd.comp   = comp_r;
      end
      ST_OUT:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

>>> src/vna_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_datapath
// Position and sum memories, edge/cross product with a shared multiplier,
// normalize, bit-serial square root, restoring divide, output register.
// ----------------------------------------------------------------------------
module vna_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vna_pkg::cmd_t                    cmd,
  output vna_pkg::sts_t                    sts,
  input  logic [1:0]                       in_func,
  input  logic [vna_pkg::SLOT_W-1:0]       in_vertex_slot,
  input  logic signed [vna_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [vna_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [vna_pkg::POS_W-1:0] in_pos_z,
  input  logic [vna_pkg::SLOT_W-1:0]       in_corner_a,
  input  logic [vna_pkg::SLOT_W-1:0]       in_corner_b,
  input  logic [vna_pkg::SLOT_W-1:0]       in_corner_c,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic signed [vna_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [vna_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [vna_pkg::NORM_W-1:0] out_normal_z,
  output logic                             out_zero_sum
);
  import vna_pkg::*;

  localparam int WORD_W = 3 * POS_W;

  // captured item
  logic [1:0]              func_r;
  logic [SLOT_W-1:0]       slot_r, ca_r, cb_r, cc_r;
  logic [WORD_W-1:0]       pos_wd_r;

  // memories, {x, y, z}
  logic [WORD_W-1:0]       pos_mem [VERTEX_DEPTH];
  logic [WORD_W-1:0]       sum_mem [VERTEX_DEPTH];
  logic [WORD_W-1:0]       pos_rd_r, sum_rd_r;

  logic [WORD_W-1:0]       pa_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [CR_W-1:0]  cr_r [3];
  logic signed [SQ_W-1:0]  prod_r;

  logic [MAG_W-1:0]        mag_r [3];
  logic                    neg_r [3];
  logic [L2_W-1:0]         l2_r;
  logic [SQ_W-1:0]         v_r, res_r, bit_r;
  logic [REM_W-1:0]        rem_r, dsh_r;
  logic [Q_W-1:0]          q_r;
  logic signed [NORM_W-1:0] u_r [3];

  logic                    out_valid_r, out_zero_r;
  logic signed [NORM_W-1:0] out_x_r, out_y_r, out_z_r;

  logic [ADDR_W-1:0]       sel_addr, sum_waddr;
  logic                    sum_we;
  logic [WORD_W-1:0]       sum_wdata;
  logic signed [31:0]      mul_a, mul_b;
  logic [MAG_W-1:0]        mag_or;
  logic [SQ_W-1:0]         root_t;
  logic                    div_ge;
  logic [Q_W-1:0]          q_fin, q_clamp;
  logic [LEN_W-1:0]        len;

  function automatic logic signed [POS_W-1:0] lane(input logic [WORD_W-1:0] w,
                                                   input int k);
    return w[WORD_W-1-k*POS_W -: POS_W];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [NORM_W-1:0] u);
    logic signed [SUM_W+1:0] t;
    logic signed [SUM_W-1:0] r;
    t = (SUM_W+2)'(s) + (SUM_W+2)'(u);
    priority if (t > (SUM_W+2)'(2**(SUM_W-1) - 1)) r = {1'b0, {(SUM_W-1){1'b1}}};
    else if (t < -(SUM_W+2)'(2**(SUM_W-1)))         r = {1'b1, {(SUM_W-1){1'b0}}};
    else                                            r = t[SUM_W-1:0];
    return r;
  endfunction

  function automatic logic in_range(input logic [SLOT_W-1:0] s);
    return 32'(s) < VERTEX_DEPTH;
  endfunction

  // ---------------- item capture ----------------
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= in_func;
      slot_r   <= in_vertex_slot;
      ca_r     <= in_corner_a;
      cb_r     <= in_corner_b;
      cc_r     <= in_corner_c;
      pos_wd_r <= {in_pos_x, in_pos_y, in_pos_z};
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_A:    sel_addr = ADDR_W'(ca_r);
      SEL_B:    sel_addr = ADDR_W'(cb_r);
      SEL_C:    sel_addr = ADDR_W'(cc_r);
      default:  sel_addr = ADDR_W'(slot_r);
    endcase
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (cmd.pos_we) pos_mem[sel_addr] <= pos_wd_r;
    if (cmd.pos_re) pos_rd_r <= pos_mem[sel_addr];
  end

  always_comb begin
    sum_we    = 1'b1;
    sum_waddr = sel_addr;
    sum_wdata = '0;
    unique case (cmd.sum_wr)
      SW_NONE:  sum_we = 1'b0;
      SW_CLEAR: sum_waddr = cmd.clr_addr;
      SW_ZERO:  sum_wdata = '0;
      default:  sum_wdata = {sat_add(lane(sum_rd_r, 0), u_r[0]),
                             sat_add(lane(sum_rd_r, 1), u_r[1]),
                             sat_add(lane(sum_rd_r, 2), u_r[2])};
    endcase
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (cmd.sum_re) sum_rd_r <= sum_mem[sel_addr];
  end

  // ---------------- edges and shared multiplier ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_kind == MK_SQUARE) begin
      unique case (cmd.mul_idx)
        3'd0:    mul_a = $signed({2'b00, mag_r[0][29:0]});
        3'd1:    mul_a = $signed({2'b00, mag_r[1][29:0]});
        default: mul_a = $signed({2'b00, mag_r[2][29:0]});
      endcase
      mul_b = mul_a;
    end else begin
      unique case (cmd.mul_idx)
        3'd0:    begin mul_a = 32'(e1_r[1]); mul_b = 32'(e2_r[2]); end
        3'd1:    begin mul_a = 32'(e1_r[2]); mul_b = 32'(e2_r[1]); end
        3'd2:    begin mul_a = 32'(e1_r[2]); mul_b = 32'(e2_r[0]); end
        3'd3:    begin mul_a = 32'(e1_r[0]); mul_b = 32'(e2_r[2]); end
        3'd4:    begin mul_a = 32'(e1_r[0]); mul_b = 32'(e2_r[1]); end
        default: begin mul_a = 32'(e1_r[1]); mul_b = 32'(e2_r[0]); end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_a) pa_r <= pos_rd_r;
    for (int k = 0; k < 3; k++) begin
      if (cmd.lat_e1) e1_r[k] <= EDGE_W'(lane(pa_r, k)) - EDGE_W'(lane(pos_rd_r, k));
      if (cmd.lat_e2) begin
        e2_r[k] <= EDGE_W'(lane(pa_r, k)) - EDGE_W'(lane(pos_rd_r, k));
        cr_r[k] <= '0;
      end
    end
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.acc_en && cmd.mul_kind == MK_CROSS) begin
      // even steps add, odd steps subtract the paired product
      if (cmd.acc_idx[0]) cr_r[cmd.acc_idx[2:1]] <= cr_r[cmd.acc_idx[2:1]] - prod_r[CR_W-1:0];
      else                cr_r[cmd.acc_idx[2:1]] <= cr_r[cmd.acc_idx[2:1]] + prod_r[CR_W-1:0];
    end
  end

  // ---------------- normalize, square root, divide ----------------
  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];
  assign root_t = res_r + bit_r;
  assign len    = res_r[LEN_W-1:0];
  assign div_ge = (rem_r >= dsh_r);
  assign q_fin  = {q_r[Q_W-2:0], div_ge};
  assign q_clamp = (q_fin > Q_W'(1 << FRAC_W)) ? Q_W'(1 << FRAC_W) : q_fin;

  always_ff @(posedge clk) begin
    if (cmd.norm_load) begin
      l2_r <= '0;
      for (int k = 0; k < 3; k++) begin
        logic signed [CR_W-1:0] c;
        unique case (cmd.norm_src)
          NS_CROSS: c = cr_r[k];
          NS_SUM:   c = CR_W'(lane(sum_rd_r, k));
          default:  c = '0;
        endcase
        neg_r[k] <= c[CR_W-1];
        mag_r[k] <= c[CR_W-1] ? MAG_W'(-c) : MAG_W'(c);
      end
    end else if (cmd.norm_shr) begin
      for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
    end else if (cmd.norm_shl) begin
      for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
    end
    if (cmd.acc_en && cmd.mul_kind == MK_SQUARE) l2_r <= l2_r + prod_r[L2_W-1:0];

    if (cmd.root_init) begin
      v_r   <= SQ_W'(l2_r);
      res_r <= '0;
      bit_r <= SQ_W'(1) << L2_W;
    end else if (cmd.root_step) begin
      if (v_r >= root_t) begin
        v_r   <= v_r - root_t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end

    if (cmd.div_init) begin
      rem_r <= REM_W'({mag_r[cmd.comp][29:0], {FRAC_W{1'b0}}}) + REM_W'(len >> 1);
      dsh_r <= REM_W'(len) << (DIV_STEPS - 1);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (div_ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= q_fin;
    end
    if (cmd.div_store) begin
      u_r[cmd.comp] <= neg_r[cmd.comp] ? -$signed(q_clamp) : $signed(q_clamp);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_zero_r <= sts.mag_zero;
      out_x_r    <= sts.mag_zero ? '0 : u_r[0];
      out_y_r    <= sts.mag_zero ? '0 : u_r[1];
      out_z_r    <= sts.mag_zero ? '0 : u_r[2];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_normal_x = out_x_r;
  assign out_normal_y = out_y_r;
  assign out_normal_z = out_z_r;
  assign out_zero_sum = out_zero_r;

  always_comb begin
    sts.mag_zero = (mag_or == '0);
    sts.mag_hi   = |mag_or[MAG_W-1:30];
    sts.mag_lo   = ~|mag_or[MAG_W-1:29];
    sts.out_free = !out_valid_r || !out_stall;
    sts.slot_ok  = in_range(slot_r);
    sts.tri_ok   = in_range(ca_r) && in_range(cb_r) && in_range(cc_r);
    sts.func     = func_r;
  end

endmodule

>>> src/vertex_normal_accumulator_core.sv
`timescale 1ns / 1ps
// Flow: a triangle or a read is normalized by one-bit shifts and, unless its
// vector is zero, then takes a square root and three divides. One item at a
// time; a result waits in the output register while the next item is taken.
// Reset: the normal sum memory is cleared one entry a cycle, all 1024 entries,
// before the first beat is accepted; vertex positions are not cleared.
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core
// Per-vertex accumulation of unit face normals with normalized readback.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [vna_pkg::SLOT_W-1:0]        in_vertex_slot,
  input  logic signed [vna_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]  in_pos_z,
  input  logic [vna_pkg::SLOT_W-1:0]        in_corner_a,
  input  logic [vna_pkg::SLOT_W-1:0]        in_corner_b,
  input  logic [vna_pkg::SLOT_W-1:0]        in_corner_c,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [vna_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [vna_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [vna_pkg::NORM_W-1:0] out_normal_z,
  output logic                              out_zero_sum
);
  import vna_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  vna_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_vertex_slot (in_vertex_slot),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_corner_a    (in_corner_a),
    .in_corner_b    (in_corner_b),
    .in_corner_c    (in_corner_c),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z),
    .out_zero_sum   (out_zero_sum)
  );

endmodule

>>> src/vna_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks for the vertex normal accumulator, bound to the top.
// ----------------------------------------------------------------------------
module vna_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        in_func,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [vna_pkg::NORM_W-1:0] out_normal_x,
  input logic signed [vna_pkg::NORM_W-1:0] out_normal_y,
  input logic signed [vna_pkg::NORM_W-1:0] out_normal_z,
  input logic                              out_zero_sum
);
  import vna_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a real item keeps the block busy in the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func != FUNC_NONE |=> in_stall)
    else $error("input taken again right after a beat");

  // zero-sum flag forces a zero normal
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_sum |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("zero sum with nonzero normal");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_normal_x) &&
      $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_zero_sum))
    else $error("stalled result changed");

endmodule

bind vertex_normal_accumulator_core vna_checker u_vna_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_normal_accumulator_core. Loads, triangles and
// reads are driven with random gaps on both channels. A predictor keeps its own
// copy of the position store and the normal sums, and the bench checks every
// read result against it in order.
// ----------------------------------------------------------------------------
module tb;
  import vna_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 600;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     zero;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = FUNC_NONE;
  logic [SLOT_W-1:0] in_vertex_slot = '0;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [SLOT_W-1:0] in_corner_a = '0, in_corner_b = '0, in_corner_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_zero_sum;

  // predictor state
  logic signed [POS_W-1:0] pos_x_mem [VERTEX_DEPTH];
  logic signed [POS_W-1:0] pos_y_mem [VERTEX_DEPTH];
  logic signed [POS_W-1:0] pos_z_mem [VERTEX_DEPTH];
  int sum_x_mem [VERTEX_DEPTH];
  int sum_y_mem [VERTEX_DEPTH];
  int sum_z_mem [VERTEX_DEPTH];
  bit loaded [VERTEX_DEPTH];

  normal_t pending_normals[$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit long_hold_req = 1'b0;
  int quiet_cycles = 0;

  vertex_normal_accumulator_core u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // returns 0 for a zero vector; outputs are Q1.14
  function automatic bit norm_q14(input longint cx, cy, cz,
                                  output logic signed [NORM_W-1:0] nx, ny, nz);
    longint c [3];
    longint unsigned m [3];
    longint unsigned mx, l2, len, q;
    bit neg [3];
    int r [3];
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      m[i] = neg[i] ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      nx = '0; ny = '0; nz = '0;
      return 1'b0;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    l2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = isqrt(l2);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      r[i] = neg[i] ? -int'(q) : int'(q);
    end
    nx = r[0][NORM_W-1:0]; ny = r[1][NORM_W-1:0]; nz = r[2][NORM_W-1:0];
    return 1'b1;
  endfunction

  function automatic int sat_add(input int s, input logic signed [NORM_W-1:0] d);
    longint t;
    t = longint'(s) + longint'(d);
    if (t > 8388607) return 8388607;
    if (t < -8388608) return -8388608;
    return int'(t);
  endfunction

  task automatic predict_beat(input logic [1:0] f, input logic [SLOT_W-1:0] slot,
                              input logic signed [POS_W-1:0] px, py, pz,
                              input logic [SLOT_W-1:0] ca, cb, cc);
    longint e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [NORM_W-1:0] ux, uy, uz;
    logic [SLOT_W-1:0] k [3];
    normal_t n;
    case (f)
      FUNC_LOAD: begin
        pos_x_mem[slot] = px; pos_y_mem[slot] = py; pos_z_mem[slot] = pz;
        sum_x_mem[slot] = 0; sum_y_mem[slot] = 0; sum_z_mem[slot] = 0;
        loaded[slot] = 1'b1;
      end
      FUNC_TRI: begin
        e1x = longint'(pos_x_mem[ca]) - longint'(pos_x_mem[cb]);
        e1y = longint'(pos_y_mem[ca]) - longint'(pos_y_mem[cb]);
        e1z = longint'(pos_z_mem[ca]) - longint'(pos_z_mem[cb]);
        e2x = longint'(pos_x_mem[ca]) - longint'(pos_x_mem[cc]);
        e2y = longint'(pos_y_mem[ca]) - longint'(pos_y_mem[cc]);
        e2z = longint'(pos_z_mem[ca]) - longint'(pos_z_mem[cc]);
        if (norm_q14(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                     e1x * e2y - e1y * e2x, ux, uy, uz)) begin
          k[0] = ca; k[1] = cb; k[2] = cc;
          for (int i = 0; i < 3; i++) begin
            sum_x_mem[k[i]] = sat_add(sum_x_mem[k[i]], ux);
            sum_y_mem[k[i]] = sat_add(sum_y_mem[k[i]], uy);
            sum_z_mem[k[i]] = sat_add(sum_z_mem[k[i]], uz);
          end
        end
      end
      FUNC_READ: begin
        n.zero = !norm_q14(sum_x_mem[slot], sum_y_mem[slot], sum_z_mem[slot],
                           n.nx, n.ny, n.nz);
        pending_normals = {pending_normals, n};
      end
      default: ;
    endcase
  endtask

  // drives one beat after a random gap and returns once it is accepted
  task automatic send_beat(input logic [1:0] f, input logic [SLOT_W-1:0] slot,
                           input logic signed [POS_W-1:0] px, py, pz,
                           input logic [SLOT_W-1:0] ca, cb, cc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f; in_vertex_slot <= slot;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_corner_a <= ca; in_corner_b <= cb; in_corner_c <= cc;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_beat(f, slot, px, py, pz, ca, cb, cc);
  endtask

  task automatic send_load(input logic [SLOT_W-1:0] slot,
                           input logic signed [POS_W-1:0] px, py, pz);
    send_beat(FUNC_LOAD, slot, px, py, pz,
              SLOT_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom));
  endtask

  task automatic send_tri(input logic [SLOT_W-1:0] ca, cb, cc);
    send_beat(FUNC_TRI, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              POS_W'($urandom), ca, cb, cc);
  endtask

  task automatic send_read(input logic [SLOT_W-1:0] slot);
    send_beat(FUNC_READ, slot, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              SLOT_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom));
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return POS_W'($urandom);
      1: return $signed(24'($urandom_range(0, 1023))) - 24'sd512;
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
    endcase
  endfunction

  // receiver: random stall per beat, one long hold on request
  initial begin
    int n;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 19);
      if (long_hold_req) begin
        n = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    normal_t n;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_normals.size() == 0) begin
        $error("result beat with no read outstanding");
        errors++;
      end else begin
        n = pending_normals.pop_front();
        if (out_normal_x !== n.nx) begin
          $error("normal_x expected %0d actual %0d", n.nx, out_normal_x); errors++;
        end
        if (out_normal_y !== n.ny) begin
          $error("normal_y expected %0d actual %0d", n.ny, out_normal_y); errors++;
        end
        if (out_normal_z !== n.nz) begin
          $error("normal_z expected %0d actual %0d", n.nz, out_normal_z); errors++;
        end
        if (out_zero_sum !== n.zero) begin
          $error("zero_sum expected %0d actual %0d", n.zero, out_zero_sum); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed();
    send_load(10'd0, 24'sh7FFFFF, 24'sh800000, 24'sh000000);
    send_load(10'd1023, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
    send_load(10'd1, 24'sh000000, 24'sh000000, 24'sh800000);
    send_load(10'd2, 24'sh010000, 24'sh000000, 24'sh000000);
    send_load(10'd3, 24'sh020000, 24'sh000000, 24'sh000000);
    send_tri(10'd0, 10'd1023, 10'd1);
    send_read(10'd0);
    send_read(10'd1023);
    send_tri(10'd0, 10'd0, 10'd1);      // repeated corner
    send_tri(10'd1, 10'd2, 10'd3);      // distinct, non-collinear corners
    send_read(10'd2);                   // holds one face normal
    send_read(10'd5);                   // never touched
    send_beat(FUNC_NONE, 10'h3FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              10'h3FF, 10'h3FF, 10'h3FF);
    send_tri(10'd2, 10'd1023, 10'd0);
    send_read(10'd1);
    send_load(10'd0, 24'sh000100, 24'sh000200, 24'sh000300);  // clears sum
    send_read(10'd0);
    send_read(10'd1023);
  endtask

  // push the z sums of three corners past positive saturation
  task automatic test_saturation();
    send_load(10'd100, 24'sh000000, 24'sh000000, 24'sh000000);
    send_load(10'd101, 24'sh010000, 24'sh000000, 24'sh000000);
    send_load(10'd102, 24'sh000000, 24'sh010000, 24'sh000000);
    for (int i = 0; i < 520; i++) send_tri(10'd100, 10'd101, 10'd102);
    send_read(10'd100);
    send_read(10'd101);
    send_read(10'd102);
  endtask

  task automatic test_random(input int count, input bit fast);
    logic [SLOT_W-1:0] pool [16];
    int sel;
    no_idle = fast;
    for (int i = 0; i < 16; i++) begin
      pool[i] = SLOT_W'($urandom);
      send_load(pool[i], rand_pos(), rand_pos(), rand_pos());
    end
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_tri(pool[$urandom_range(0, 15)], pool[$urandom_range(0, 15)],
                 pool[$urandom_range(0, 15)]);
      end else if (sel < 75) begin
        send_read($urandom_range(0, 3) == 0 ? 10'($urandom) : pool[$urandom_range(0, 15)]);
      end else if (sel < 93) begin
        send_load(pool[$urandom_range(0, 15)], rand_pos(), rand_pos(), rand_pos());
      end else begin
        send_beat(FUNC_NONE, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  POS_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom),
                  SLOT_W'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while reads keep coming, so the input backs up
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_read(10'd100 + 10'(i % 3));
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_saturation();
    test_random(250, 1'b0);
    test_random(60, 1'b1);
    test_backpressure();
    test_random(250, 1'b0);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_normals.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> sim.f
src/vna_pkg.sv
src/vna_ctrl.sv
src/vna_datapath.sv
src/vertex_normal_accumulator_core.sv
src/vna_checker.sv
test/tb.sv
